/* rtl/rotate_then_drive_go_to_goal_core_macros.svh */
// Assertion macros for the checker file of this block.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef ROTATE_THEN_DRIVE_GO_TO_GOAL_CORE_MACROS_SVH
`define ROTATE_THEN_DRIVE_GO_TO_GOAL_CORE_MACROS_SVH
// Same-cycle implication.
`define RTGG_ASSERT_IMP(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("rtgg assertion failed");
// Delayed implication; the delay is given by the argument n.
`define RTGG_ASSERT_DLY(lbl, a, n, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> ##n (b)) \
		else $error("rtgg latency assertion failed");
`endif

/* rtl/rtgg_pkg.sv */
// ----------------------------------------------------------------------------
// rtgg_pkg
// Types, widths, angle constants and the arctangent table of the controller.
// ----------------------------------------------------------------------------
package rtgg_pkg;

	// Default number of vectoring stages in the arctangent pipeline.
	localparam int CORDIC_STAGES_DEF = 16;

	// Datapath widths.
	localparam int CW = 37;   // vector components inside the rotator
	localparam int ZW = 34;   // Q3.29 angle accumulator
	localparam int EW = 37;   // heading error before rounding
	localparam int RW = 22;   // rounded Q3.13 error
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_REACH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALIGN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CRUISE = 3'd4;

	// Reset values of the registers.
	localparam logic [15:0] REACH_RST = 16'd1966;
	localparam logic [14:0] ALIGN_RST = 15'd819;
	localparam logic [14:0] GAIN_RST = 15'd4096;
	localparam logic [14:0] LIMIT_RST = 15'd819;
	localparam logic [14:0] CRUISE_RST = 15'd410;

	// Pi and two pi in Q3.29.
	localparam logic signed [EW-1:0] ANG_PI = 37'sd1686629713;
	localparam logic signed [EW-1:0] ANG_TWO_PI = 37'sd3373259426;

	// How the yaw follows from the rotator angle.
	typedef enum logic [1:0] {
		YAW_DIRECT = 2'd0,
		YAW_NEG2 = 2'd1,
		YAW_POS2 = 2'd2
	} yaw_mode_t;

	// Arctangent of 2^-i in Q3.29.
	function automatic logic signed [ZW-1:0] atan_step(input int unsigned i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 34'sd421657428;
			1: r = 34'sd248918915;
			2: r = 34'sd131521918;
			3: r = 34'sd66762579;
			4: r = 34'sd33510843;
			5: r = 34'sd16771758;
			6: r = 34'sd8387925;
			7: r = 34'sd4194219;
			8: r = 34'sd2097141;
			9: r = 34'sd1048575;
			default: begin
				if (i >= 30) r = '0;
				else r = ZW'(34'sd536870912 >>> i);
			end
		endcase
		return r;
	endfunction

endpackage

/* rtl/rtgg_cordic.sv */
// ----------------------------------------------------------------------------
// rtgg_cordic
// Two-lane pipelined vectoring rotator giving atan2(y, x) in Q3.29.
// ----------------------------------------------------------------------------
module rtgg_cordic #(
	parameter int STAGES = rtgg_pkg::CORDIC_STAGES_DEF,
	parameter int TAG_W = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [TAG_W-1:0] in_tag,
	input  logic signed [rtgg_pkg::CW-1:0] in_x [2],
	input  logic signed [rtgg_pkg::CW-1:0] in_y [2],
	output logic out_valid,
	output logic [TAG_W-1:0] out_tag,
	output logic signed [rtgg_pkg::ZW-1:0] out_z [2]
);
	import rtgg_pkg::*;

	// Stage 0 holds the prerotated vector, stage k the result of step k-1.
	logic signed [CW-1:0] x_s [STAGES+1][2];
	logic signed [CW-1:0] y_s [STAGES+1][2];
	logic signed [ZW-1:0] z_s [STAGES+1][2];
	logic v_s [STAGES+1];
	logic [TAG_W-1:0] tag_s [STAGES+1];

	// Valid bits for every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STAGES; k++) v_s[k] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
			for (int k = 1; k <= STAGES; k++) v_s[k] <= v_s[k-1];
		end
	end

	// Half-turn prerotation into the right half plane.
	always_ff @(posedge clk) begin
		tag_s[0] <= in_tag;
		for (int l = 0; l < 2; l++) begin
			if (in_x[l] < 0) begin
				x_s[0][l] <= -in_x[l];
				y_s[0][l] <= -in_y[l];
				z_s[0][l] <= (in_y[l] >= 0) ? ZW'(ANG_PI) : -ZW'(ANG_PI);
			end else begin
				x_s[0][l] <= in_x[l];
				y_s[0][l] <= in_y[l];
				z_s[0][l] <= '0;
			end
		end
	end

	// One vectoring step per stage.
	for (genvar k = 1; k <= STAGES; k++) begin : g_step
		always_ff @(posedge clk) begin
			tag_s[k] <= tag_s[k-1];
			for (int l = 0; l < 2; l++) begin
				if (y_s[k-1][l] >= 0) begin
					x_s[k][l] <= x_s[k-1][l] + (y_s[k-1][l] >>> (k-1));
					y_s[k][l] <= y_s[k-1][l] - (x_s[k-1][l] >>> (k-1));
					z_s[k][l] <= z_s[k-1][l] + atan_step(k-1);
				end else begin
					x_s[k][l] <= x_s[k-1][l] - (y_s[k-1][l] >>> (k-1));
					y_s[k][l] <= y_s[k-1][l] + (x_s[k-1][l] >>> (k-1));
					z_s[k][l] <= z_s[k-1][l] - atan_step(k-1);
				end
			end
		end
	end

	assign out_valid = v_s[STAGES];
	assign out_tag = tag_s[STAGES];
	assign out_z[0] = z_s[STAGES][0];
	assign out_z[1] = z_s[STAGES][1];

endmodule

/* rtl/rotate_then_drive_go_to_goal_core.sv */
// ----------------------------------------------------------------------------
// rotate_then_drive_go_to_goal_core
// Go-to-goal controller that turns in place until aligned, then drives.
// ----------------------------------------------------------------------------
// Usage:
// A pose beat (position, quaternion, goal) is taken at each clock edge where
// start is high and busy is low. busy stays low, so a beat may enter in every
// cycle; throughput is one beat per cycle.
// Each beat yields one command beat on forward_speed, turn_rate and arrived,
// marked by done for exactly one cycle. Each pose beat passes through the
// three front stages (differences and products, squares, compares), the
// prerotation and one register per arctangent step, and three back stages
// (error, rounding, gain multiply) plus the output register.
// The receiver cannot stall: done is never held off.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; it writes registers 0..4, other indexes are ignored. The
// user must make writes only while no beat is in flight; the block does
// not enforce this. Reset clears all valid bits and loads the register
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rotate_then_drive_go_to_goal_core #(
	parameter int CORDIC_STAGES = rtgg_pkg::CORDIC_STAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	input  logic signed [23:0] goal_x,
	input  logic signed [23:0] goal_y,
	output logic done,
	output logic signed [15:0] forward_speed,
	output logic signed [15:0] turn_rate,
	output logic arrived,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [rtgg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rtgg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rtgg_pkg::*;

	localparam int TAG_W = 3;

	logic [15:0] reach_q;
	logic [14:0] align_q, gain_q, limit_q, cruise_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q <= REACH_RST;
			align_q <= ALIGN_RST;
			gain_q <= GAIN_RST;
			limit_q <= LIMIT_RST;
			cruise_q <= CRUISE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_REACH: reach_q <= cfg_data;
				REG_ALIGN: align_q <= cfg_data[14:0];
				REG_GAIN: gain_q <= cfg_data[14:0];
				REG_LIMIT: limit_q <= cfg_data[14:0];
				REG_CRUISE: cruise_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Valid bits of the front and back stages.
	logic v_s1, v_s2, v_s3, v_s5, v_s6, v_s7, v_s8;
	logic cv_out;
	logic [TAG_W-1:0] ctag_out;
	logic signed [ZW-1:0] cz_out [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s5 <= cv_out;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Stage 1: differences and quaternion products.
	logic signed [24:0] dx_s1, dy_s1;
	logic signed [15:0] qx_s1, qy_s1;
	logic signed [31:0] xx_s1, yy_s1, zz_s1, ww_s1, xz_s1, wy_s1, xy_s1, wz_s1;

	always_ff @(posedge clk) begin
		dx_s1 <= 25'(goal_x) - 25'(pos_x);
		dy_s1 <= 25'(goal_y) - 25'(pos_y);
		qx_s1 <= quat_x;
		qy_s1 <= quat_y;
		xx_s1 <= 32'(quat_x) * 32'(quat_x);
		yy_s1 <= 32'(quat_y) * 32'(quat_y);
		zz_s1 <= 32'(quat_z) * 32'(quat_z);
		ww_s1 <= 32'(quat_w) * 32'(quat_w);
		xz_s1 <= 32'(quat_x) * 32'(quat_z);
		wy_s1 <= 32'(quat_w) * 32'(quat_y);
		xy_s1 <= 32'(quat_x) * 32'(quat_y);
		wz_s1 <= 32'(quat_w) * 32'(quat_z);
	end

	// Stage 2: distance squares, quaternion norm and yaw arguments.
	logic signed [24:0] dx_s2, dy_s2;
	logic signed [15:0] qx_s2, qy_s2;
	logic [49:0] dxx_s2, dyy_s2;
	logic [31:0] rr_s2;
	logic signed [34:0] n_s2, s_s2;
	logic signed [34:0] ya_s2, xa_s2;

	always_ff @(posedge clk) begin
		dx_s2 <= dx_s1;
		dy_s2 <= dy_s1;
		qx_s2 <= qx_s1;
		qy_s2 <= qy_s1;
		dxx_s2 <= 50'(50'(dx_s1) * 50'(dx_s1));
		dyy_s2 <= 50'(50'(dy_s1) * 50'(dy_s1));
		rr_s2 <= 32'(reach_q) * 32'(reach_q);
		n_s2 <= 35'(xx_s1) + 35'(yy_s1) + 35'(zz_s1) + 35'(ww_s1);
		s_s2 <= -((35'(xz_s1) - 35'(wy_s1)) <<< 1);
		ya_s2 <= (35'(xy_s1) + 35'(wz_s1)) <<< 1;
		xa_s2 <= 35'(ww_s1) + 35'(xx_s1) - 35'(yy_s1) - 35'(zz_s1);
	end

	// Stage 3: reach compare and scaled near-singularity terms.
	logic signed [24:0] dx_s3, dy_s3;
	logic signed [15:0] qx_s3, qy_s3;
	logic signed [34:0] ya_s3, xa_s3;
	logic arrived_s3, npos_s3;
	logic signed [52:0] sm_s3, nm_s3;

	always_ff @(posedge clk) begin
		dx_s3 <= dx_s2;
		dy_s3 <= dy_s2;
		qx_s3 <= qx_s2;
		qy_s3 <= qy_s2;
		ya_s3 <= ya_s2;
		xa_s3 <= xa_s2;
		arrived_s3 <= (51'(dxx_s2) + 51'(dyy_s2)) < 51'(rr_s2);
		npos_s3 <= n_s2 > 0;
		sm_s3 <= 53'(s_s2) * 53'sd100000;
		nm_s3 <= 53'(n_s2) * 53'sd99999;
	end

	// Yaw mode selection and rotator inputs.
	yaw_mode_t mode_c;
	logic signed [CW-1:0] cx_c [2];
	logic signed [CW-1:0] cy_c [2];

	always_comb begin
		if (npos_s3 && (sm_s3 <= -nm_s3)) mode_c = YAW_NEG2;
		else if (npos_s3 && (sm_s3 >= nm_s3)) mode_c = YAW_POS2;
		else mode_c = YAW_DIRECT;
		cx_c[0] = CW'(dx_s3);
		cy_c[0] = CW'(dy_s3);
		if (mode_c == YAW_DIRECT) begin
			cx_c[1] = CW'(xa_s3);
			cy_c[1] = CW'(ya_s3);
		end else begin
			cx_c[1] = CW'(qx_s3);
			cy_c[1] = CW'(qy_s3);
		end
	end

	rtgg_cordic #(
		.STAGES(CORDIC_STAGES),
		.TAG_W(TAG_W)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s3),
		.in_tag({arrived_s3, mode_c}),
		.in_x(cx_c),
		.in_y(cy_c),
		.out_valid(cv_out),
		.out_tag(ctag_out),
		.out_z(cz_out)
	);

	// Stage 5: raw heading error.
	yaw_mode_t cmode;
	logic signed [EW-1:0] yaw_c;
	logic signed [EW-1:0] e_s5;
	logic arrived_s5;

	always_comb begin
		cmode = yaw_mode_t'(ctag_out[1:0]);
		case (cmode)
			YAW_NEG2: yaw_c = -(EW'(cz_out[1]) <<< 1);
			YAW_POS2: yaw_c = EW'(cz_out[1]) <<< 1;
			default: yaw_c = EW'(cz_out[1]);
		endcase
	end

	always_ff @(posedge clk) begin
		e_s5 <= EW'(cz_out[0]) - yaw_c;
		arrived_s5 <= ctag_out[2];
	end

	// Stage 6: single wrap into [-pi, pi] and rounding to Q3.13.
	logic signed [EW-1:0] ew_c;
	logic signed [EW:0] er_c;
	logic signed [RW-1:0] err_s6;
	logic arrived_s6;

	always_comb begin
		if (e_s5 > ANG_PI) ew_c = e_s5 - ANG_TWO_PI;
		else if (e_s5 < -ANG_PI) ew_c = e_s5 + ANG_TWO_PI;
		else ew_c = e_s5;
		er_c = (EW+1)'(ew_c) + (EW+1)'(32768);
	end

	always_ff @(posedge clk) begin
		err_s6 <= RW'(er_c >>> 16);
		arrived_s6 <= arrived_s5;
	end

	// Stage 7: alignment test and gain multiply.
	logic signed [RW-1:0] abs_c;
	logic signed [RW+15:0] prod_s7;
	logic turning_s7, arrived_s7;

	assign abs_c = (err_s6 < 0) ? -err_s6 : err_s6;

	always_ff @(posedge clk) begin
		turning_s7 <= abs_c > RW'(align_q);
		prod_s7 <= (RW+16)'(gain_q) * (RW+16)'(err_s6);
		arrived_s7 <= arrived_s6;
	end

	// Stage 8: rounding, clamp and output register.
	logic signed [RW+16:0] tr_c;
	logic signed [RW+16:0] lim_c;
	logic signed [15:0] turn_c;

	always_comb begin
		tr_c = ((RW+17)'(prod_s7) + (RW+17)'(4096)) >>> 13;
		lim_c = (RW+17)'(limit_q);
		if (tr_c > lim_c) turn_c = 16'(lim_c);
		else if (tr_c < -lim_c) turn_c = 16'(-lim_c);
		else turn_c = 16'(tr_c);
	end

	always_ff @(posedge clk) begin
		if (arrived_s7) begin
			forward_speed <= '0;
			turn_rate <= '0;
		end else if (turning_s7) begin
			forward_speed <= '0;
			turn_rate <= turn_c;
		end else begin
			forward_speed <= 16'(cruise_q);
			turn_rate <= '0;
		end
		arrived <= arrived_s7;
	end

	assign done = v_s8;

endmodule

/* rtl/rtgg_checker.sv */
// ----------------------------------------------------------------------------
// rtgg_checker
// Port-level assertions on the command results of the controller.
// ----------------------------------------------------------------------------
`include "rotate_then_drive_go_to_goal_core_macros.svh"

module rtgg_checker #(
	parameter int LATENCY = rtgg_pkg::CORDIC_STAGES_DEF + 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic done,
	input  logic signed [15:0] forward_speed,
	input  logic signed [15:0] turn_rate,
	input  logic arrived
);
	// An arrived beat commands no motion.
	`RTGG_ASSERT_IMP(a_arrived_zero, done && arrived, forward_speed == 0 && turn_rate == 0)
	// The block never turns and drives in the same beat.
	`RTGG_ASSERT_IMP(a_one_motion, done, forward_speed == 0 || turn_rate == 0)
	// Every accepted pose later gives a result on done.
	`RTGG_ASSERT_DLY(a_latency, start && !busy, LATENCY, done)
	// Without an accepted pose no result appears.
	`RTGG_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, LATENCY))

endmodule

bind rotate_then_drive_go_to_goal_core rtgg_checker #(
	.LATENCY(CORDIC_STAGES + 8)
) u_rtgg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.forward_speed(forward_speed),
	.turn_rate(turn_rate),
	.arrived(arrived)
);
